// ----- rtl/touch_point_smoother_tracker_assert.svh -----
// Assertion macros for the touch point smoother and tracker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef TOUCH_POINT_SMOOTHER_TRACKER_ASSERT_SVH
`define TOUCH_POINT_SMOOTHER_TRACKER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TPST_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define TPST_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/tpst_pkg.sv -----
// Package of the touch point smoother and tracker: register indexes,
// field widths, reset values and dead band thresholds. No dependencies.
`default_nettype none

package tpst_pkg;

	// Field widths fixed by the record format.
	localparam int ID_W   = 4;
	localparam int RAWX_W = 12;
	localparam int RAWY_W = 16;
	localparam int WLIM_W = 16;
	localparam int HLIM_W = 13;
	localparam int CFG_W  = 16;

	// Default sizes of the tracker.
	localparam int MAX_IDS_DEF     = 10;
	localparam int MAX_RECORDS_DEF = 10;

	// Configuration register indexes.
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_SCREEN_WIDTH  = 1'b0;
	localparam cfg_index_t CFG_SCREEN_HEIGHT = 1'b1;

	// Reset values of the screen limits.
	localparam logic [WLIM_W-1:0] WLIM_RESET = 16'd65535;
	localparam logic [HLIM_W-1:0] HLIM_RESET = 13'd4096;

	// Input kind codes.
	localparam logic KIND_CONTACT = 1'b0;
	localparam logic KIND_EMPTY   = 1'b1;

	// Dead band: a single axis moves above BIG, a joint move also needs the
	// other axis above SMALL.
	localparam int DB_BIG   = 3;
	localparam int DB_SMALL = 1;

endpackage

`default_nettype wire

// ----- rtl/touch_point_smoother_tracker.sv -----
// Top level of the touch point smoother and tracker.
// Depends on tpst_pkg and on touch_point_smoother_tracker_assert.svh.
//
// Takes one contact record (or one empty frame marker) per transaction and
// delivers at most one smoothed point per record, axes swapped. Each
// accepted record is fully processed in the cycle it is accepted: the per-ID
// position and flag registers are read, averaged, dead band filtered and
// written back in that cycle, and the point lands in a single output
// register in the cycle after. An item can therefore be accepted every cycle,
// and in_ready stays high while that output register is empty or being
// taken in the same cycle; a stalled output holds the input off.
// Configuration writes take effect at the next edge and are meant for idle
// periods only.
`default_nettype none

module touch_point_smoother_tracker
	import tpst_pkg::*;
#(
	parameter int MAX_IDS     = MAX_IDS_DEF,
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write port.
	input  wire logic              cfg_we,
	input  wire cfg_index_t        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// Input channel.
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic [ID_W-1:0]   contact_id,
	input  wire logic [RAWX_W-1:0] raw_x,
	input  wire logic [RAWY_W-1:0] raw_y,
	input  wire logic              frame_last,
	// Output channel.
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [RAWY_W-1:0]      report_x,
	output logic [RAWX_W-1:0]      report_y,
	output logic [ID_W-1:0]        report_id
);

	localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	// Screen limit registers.
	logic [WLIM_W-1:0] wlim_q;
	logic [HLIM_W-1:0] hlim_q;

	// Per-ID tracking state.
	logic [RAWX_W-1:0]  last_x_q [MAX_IDS];
	logic [RAWY_W-1:0]  last_y_q [MAX_IDS];
	logic [MAX_IDS-1:0] seen_q, pres_now_q, pres_before_q;
	logic [CNT_W-1:0]   rec_cnt_q;

	// Output register.
	logic              out_valid_q;
	logic [RAWY_W-1:0] rep_x_q;
	logic [RAWX_W-1:0] rep_y_q;
	logic [ID_W-1:0]   rep_id_q;

	logic in_fire;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q <= WLIM_RESET;
			hlim_q <= HLIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  wlim_q <= cfg_data[WLIM_W-1:0];
				CFG_SCREEN_HEIGHT: hlim_q <= cfg_data[HLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Record classification.
	logic             id_ok, room, upd;
	logic [IDX_W-1:0] idx;
	assign id_ok = (contact_id != '0) && (contact_id <= ID_W'(MAX_IDS));
	assign idx   = IDX_W'(contact_id - ID_W'(1));
	assign room  = rec_cnt_q < CNT_W'(MAX_RECORDS);
	assign upd   = in_fire && (kind == KIND_CONTACT) && room && id_ok;

	// Averaging and dead band. An unseen ID starts from the raw point itself.
	logic [RAWX_W-1:0] base_x, avg_x, dx, new_x;
	logic [RAWY_W-1:0] base_y, avg_y, dy, new_y;
	logic [RAWX_W:0]   sum_x;
	logic [RAWY_W:0]   sum_y;
	logic              dx_big, dy_big, dx_mid, dy_mid, joint, in_bounds;

	always_comb begin
		base_x = seen_q[idx] ? last_x_q[idx] : raw_x;
		base_y = seen_q[idx] ? last_y_q[idx] : raw_y;
		sum_x  = {1'b0, base_x} + {1'b0, raw_x};
		sum_y  = {1'b0, base_y} + {1'b0, raw_y};
		avg_x  = sum_x[RAWX_W:1];
		avg_y  = sum_y[RAWY_W:1];
		dx     = (avg_x > base_x) ? (avg_x - base_x) : (base_x - avg_x);
		dy     = (avg_y > base_y) ? (avg_y - base_y) : (base_y - avg_y);
		dx_big = dx > RAWX_W'(DB_BIG);
		dy_big = dy > RAWY_W'(DB_BIG);
		dx_mid = dx > RAWX_W'(DB_SMALL);
		dy_mid = dy > RAWY_W'(DB_SMALL);
		joint  = (dx_big && dy_mid) || (dx_mid && dy_big);
		new_x  = (joint || dx_big) ? avg_x : base_x;
		new_y  = (joint || dy_big) ? avg_y : base_y;
		in_bounds = (new_y < wlim_q) && ({1'b0, new_x} < hlim_q);
	end

	// Next values of the flags and the record counter, frame end included.
	logic [MAX_IDS-1:0] seen_d, now_d, before_d;
	logic [CNT_W-1:0]   cnt_d;

	always_comb begin
		seen_d   = seen_q;
		now_d    = pres_now_q;
		before_d = pres_before_q;
		cnt_d    = rec_cnt_q;
		if (in_fire) begin
			if (kind == KIND_EMPTY) begin
				seen_d   = '0;
				now_d    = '0;
				before_d = '0;
				cnt_d    = '0;
			end else begin
				if (room) begin
					cnt_d = rec_cnt_q + CNT_W'(1);
				end
				if (upd) begin
					seen_d[idx] = 1'b1;
					now_d[idx]  = 1'b1;
				end
				if (frame_last) begin
					seen_d   = seen_d & ~(before_d & ~now_d);
					before_d = now_d;
					now_d    = '0;
					cnt_d    = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= '0;
			pres_now_q    <= '0;
			pres_before_q <= '0;
			rec_cnt_q     <= '0;
		end else begin
			seen_q        <= seen_d;
			pres_now_q    <= now_d;
			pres_before_q <= before_d;
			rec_cnt_q     <= cnt_d;
		end
	end

	// Stored positions; only read once the seen flag is set, so no reset.
	always_ff @(posedge clk) begin
		if (upd) begin
			last_x_q[idx] <= new_x;
			last_y_q[idx] <= new_y;
		end
	end

	// Output register: loads a point that lies on screen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd && in_bounds) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && in_bounds) begin
			rep_x_q  <= new_y;
			rep_y_q  <= new_x;
			rep_id_q <= contact_id;
		end
	end

	assign out_valid = out_valid_q;
	assign report_x  = rep_x_q;
	assign report_y  = rep_y_q;
	assign report_id = rep_id_q;

	// Checks on the tracking state.
	`include "touch_point_smoother_tracker_assert.svh"

	`TPST_ASSERT_ALWAYS(a_cnt_range, rec_cnt_q <= CNT_W'(MAX_RECORDS), "record count overflow")
	`TPST_ASSERT_ALWAYS(a_now_seen, (pres_now_q & ~seen_q) == '0, "present ID not seen")
	`TPST_ASSERT_NEXT(a_empty_clear, in_fire && kind == KIND_EMPTY, seen_q == '0 && pres_before_q == '0 && rec_cnt_q == '0, "empty frame left state")
	`TPST_ASSERT_NEXT(a_frame_end, in_fire && kind == KIND_CONTACT && frame_last, pres_now_q == '0 && rec_cnt_q == '0, "frame end left state")
	`TPST_ASSERT_ALWAYS(a_out_id, !out_valid_q || (rep_id_q != '0 && rep_id_q <= ID_W'(MAX_IDS)), "bad report id")

endmodule

`default_nettype wire

// ----- dv/touch_point_smoother_tracker_test.sv -----
// Testbench of the touch point smoother and tracker: random and directed touch
// frames, checked against a predictor kept in a small scoreboard class.
// Depends on tpst_pkg and on the RTL top level touch_point_smoother_tracker.
`default_nettype none

module touch_point_smoother_tracker_test;
	import tpst_pkg::*;

	// One smoothed point as the block reports it.
	typedef struct {
		logic [RAWY_W-1:0] x;
		logic [RAWX_W-1:0] y;
		logic [ID_W-1:0]   id;
	} touch_point_t;

	// Tracks per-ID positions and flags and holds the points still awaited.
	class smoothed_point_board;
		logic [WLIM_W-1:0] width_limit;
		logic [HLIM_W-1:0] height_limit;
		logic [RAWX_W-1:0] pos_x [16];
		logic [RAWY_W-1:0] pos_y [16];
		bit                seen [16];
		bit                present_now [16];
		bit                present_before [16];
		int unsigned       records;
		touch_point_t      awaited_points [$];
		int                errors;

		function new();
			width_limit = WLIM_RESET;
			height_limit = HLIM_RESET;
			records = 0;
			errors = 0;
			for (int i = 0; i < 16; i++) begin
				pos_x[i] = '0;
				pos_y[i] = '0;
				seen[i] = 1'b0;
				present_now[i] = 1'b0;
				present_before[i] = 1'b0;
			end
		endfunction

		function void write_limit(cfg_index_t idx, logic [CFG_W-1:0] data);
			if (idx == CFG_SCREEN_WIDTH) begin
				width_limit = data[WLIM_W-1:0];
			end else begin
				height_limit = data[HLIM_W-1:0];
			end
		endfunction

		// Frame end: drop IDs that vanished, or every ID after an empty frame.
		function void close_frame(bit empty);
			for (int i = 0; i < 16; i++) begin
				if (empty || (present_before[i] && !present_now[i]))
					seen[i] = 1'b0;
				present_before[i] = empty ? 1'b0 : present_now[i];
				present_now[i] = 1'b0;
			end
			records = 0;
		endfunction

		// Notes one accepted input transaction and queues the point it causes.
		function void take_record(logic k, logic [ID_W-1:0] id, logic [RAWX_W-1:0] rx,
				logic [RAWY_W-1:0] ry, logic last);
			int ax, ay, dx, dy;
			touch_point_t pt;
			if (k == KIND_EMPTY) begin
				close_frame(1'b1);
				return;
			end
			if (records < MAX_RECORDS_DEF) begin
				records++;
				if (id >= 1 && id <= MAX_IDS_DEF) begin
					if (!seen[id]) begin
						pos_x[id] = rx;
						pos_y[id] = ry;
						seen[id] = 1'b1;
					end
					ax = (int'(pos_x[id]) + int'(rx)) >> 1;
					ay = (int'(pos_y[id]) + int'(ry)) >> 1;
					dx = (ax > int'(pos_x[id])) ? ax - int'(pos_x[id]) : int'(pos_x[id]) - ax;
					dy = (ay > int'(pos_y[id])) ? ay - int'(pos_y[id]) : int'(pos_y[id]) - ay;
					// Dead band: a joint move updates both axes, else each axis alone.
					if ((dx > DB_BIG && dy > DB_SMALL) || (dx > DB_SMALL && dy > DB_BIG)) begin
						pos_x[id] = ax[RAWX_W-1:0];
						pos_y[id] = ay[RAWY_W-1:0];
					end else begin
						if (dx > DB_BIG)
							pos_x[id] = ax[RAWX_W-1:0];
						if (dy > DB_BIG)
							pos_y[id] = ay[RAWY_W-1:0];
					end
					present_now[id] = 1'b1;
					if (pos_y[id] < width_limit && pos_x[id] < height_limit) begin
						pt.x = pos_y[id];
						pt.y = pos_x[id];
						pt.id = id;
						awaited_points.push_back(pt);
					end
				end
			end
			if (last)
				close_frame(1'b0);
		endfunction

		// Compares one output transaction with the oldest awaited point.
		function void match_point(logic [RAWY_W-1:0] x, logic [RAWX_W-1:0] y,
				logic [ID_W-1:0] id);
			touch_point_t pt;
			if (awaited_points.size() == 0) begin
				$display("%0t: unexpected point x %0d y %0d id %0d", $time, x, y, id);
				errors++;
				return;
			end
			pt = awaited_points.pop_front();
			if (x !== pt.x) begin
				$display("%0t: report_x expected %0d actual %0d", $time, pt.x, x);
				errors++;
			end
			if (y !== pt.y) begin
				$display("%0t: report_y expected %0d actual %0d", $time, pt.y, y);
				errors++;
			end
			if (id !== pt.id) begin
				$display("%0t: report_id expected %0d actual %0d", $time, pt.id, id);
				errors++;
			end
		endfunction

		function int awaited_count();
			return awaited_points.size();
		endfunction

		function void check_leftovers();
			if (awaited_points.size() != 0) begin
				$display("%0t: %0d points expected but never reported", $time,
					awaited_points.size());
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	cfg_index_t        cfg_index = CFG_SCREEN_WIDTH;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              kind = KIND_CONTACT;
	logic [ID_W-1:0]   contact_id = '0;
	logic [RAWX_W-1:0] raw_x = '0;
	logic [RAWY_W-1:0] raw_y = '0;
	logic              frame_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [RAWY_W-1:0] report_x;
	logic [RAWX_W-1:0] report_y;
	logic [ID_W-1:0]   report_id;

	smoothed_point_board board = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int records_sent = 0;
	int finger_x [16];
	int finger_y [16];
	int frame_base = 0;

	touch_point_smoother_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.contact_id (contact_id),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.report_x   (report_x),
		.report_y   (report_y),
		.report_id  (report_id)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = 300;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: sample every transaction and register write at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.match_point(report_x, report_y, report_id);
			if (in_valid && in_ready)
				board.take_record(kind, contact_id, raw_x, raw_y, frame_last);
			if (cfg_we)
				board.write_limit(cfg_index, cfg_data);
		end
	end

	// Offers one input transaction, waits for it to be taken, then maybe idles.
	task automatic send_record(logic k, logic [ID_W-1:0] id, logic [RAWX_W-1:0] x,
			logic [RAWY_W-1:0] y, logic last);
		in_valid <= 1'b1;
		kind <= k;
		contact_id <= id;
		raw_x <= x;
		raw_y <= y;
		frame_last <= last;
		do @(posedge clk); while (!in_ready);
		records_sent++;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every awaited point has come out.
	task automatic settle_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 20000 && board.awaited_count() > 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Moves a finger by a tiny, small, medium or unbounded step.
	task automatic move_finger(int id);
		case ($urandom_range(3))
			0: begin
				finger_x[id] += $urandom_range(4) - 2;
				finger_y[id] += $urandom_range(4) - 2;
			end
			1: begin
				finger_x[id] += $urandom_range(16) - 8;
				finger_y[id] += $urandom_range(16) - 8;
			end
			2: begin
				finger_x[id] += $urandom_range(80) - 40;
				finger_y[id] += $urandom_range(80) - 40;
			end
			default: begin
				finger_x[id] = $urandom_range(4095);
				finger_y[id] = $urandom_range(65535);
			end
		endcase
		if (finger_x[id] < 0) finger_x[id] = 0;
		if (finger_x[id] > 4095) finger_x[id] = 4095;
		if (finger_y[id] < 0) finger_y[id] = 0;
		if (finger_y[id] > 65535) finger_y[id] = 65535;
	endtask

	// One random frame: mostly well formed, sometimes overlong or broken.
	task automatic send_frame();
		int pick, n, id;
		logic last;
		pick = $urandom_range(99);
		if (pick < 4) begin
			send_record(KIND_EMPTY, ID_W'($urandom_range(15)), RAWX_W'($urandom_range(4095)),
				RAWY_W'($urandom_range(65535)), 1'($urandom_range(1)));
			return;
		end
		n = (pick < 10) ? $urandom_range(11, 13) : $urandom_range(1, 6);
		if ($urandom_range(99) < 30)
			frame_base = $urandom_range(9);
		for (int k = 0; k < n; k++) begin
			id = (frame_base + k) % MAX_IDS_DEF + 1;
			if ($urandom_range(99) < 8)
				id = $urandom_range(1) ? 0 : $urandom_range(11, 15);
			move_finger(id);
			last = (k == n - 1);
			if ($urandom_range(99) < 3)
				last = !last;
			send_record(KIND_CONTACT, ID_W'(id), RAWX_W'(finger_x[id]),
				RAWY_W'(finger_y[id]), last);
		end
	endtask

	task automatic run_frames(int count);
		int target;
		target = records_sent + count;
		while (records_sent < target)
			send_frame();
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			finger_x[i] = $urandom_range(4095);
			finger_y[i] = $urandom_range(65535);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first sight, dead band cases, bad IDs, frame rules, extremes.
		send_record(KIND_CONTACT, 4'd1, 12'd0, 16'd0, 1'b0);
		send_record(KIND_CONTACT, 4'd10, 12'd4095, 16'd65535, 1'b1);
		send_record(KIND_CONTACT, 4'd1, 12'd16, 16'd2, 1'b0);
		send_record(KIND_CONTACT, 4'd10, 12'd4087, 16'd65531, 1'b1);
		send_record(KIND_CONTACT, 4'd1, 12'd12, 16'd12, 1'b0);
		send_record(KIND_CONTACT, 4'd10, 12'd4091, 16'd65533, 1'b1);
		send_record(KIND_CONTACT, 4'd0, 12'd100, 16'd100, 1'b0);
		send_record(KIND_CONTACT, 4'd11, 12'd200, 16'd200, 1'b0);
		send_record(KIND_CONTACT, 4'd15, 12'd4095, 16'd65535, 1'b1);
		send_record(KIND_CONTACT, 4'd1, 12'd300, 16'd400, 1'b1);
		send_record(KIND_EMPTY, 4'd5, 12'd4095, 16'd65535, 1'b1);
		// Eleven records in one frame: the last is over the limit but ends the frame.
		for (int k = 1; k <= MAX_RECORDS_DEF; k++)
			send_record(KIND_CONTACT, ID_W'(k), RAWX_W'(k * 300), RAWY_W'(k * 6000), 1'b0);
		send_record(KIND_CONTACT, 4'd3, 12'd50, 16'd50, 1'b1);
		send_record(KIND_CONTACT, 4'd2, 12'd4095, 16'd0, 1'b1);
		send_record(KIND_EMPTY, 4'd0, 12'd0, 16'd0, 1'b0);
		send_record(KIND_CONTACT, 4'd4, 12'd1, 16'd65534, 1'b1);
		settle_outputs();

		// Widest screen, no idling.
		write_limits(16'd65535, 16'd4096);
		run_frames(250);
		settle_outputs();

		// Mid-size screen, sender idles often.
		write_limits(16'd30000, 16'd2000);
		send_idle_pct = 57;
		run_frames(250);
		settle_outputs();

		// Smallest screen, receiver stalls often.
		write_limits(16'd1, 16'd1);
		send_idle_pct = 0;
		recv_stall_pct = 57;
		run_frames(100);
		settle_outputs();

		// Random large screen, both sides idle, with one long receiver hold-off.
		write_limits(CFG_W'($urandom_range(32768, 65535)), CFG_W'($urandom_range(2048, 4096)));
		send_idle_pct = 24;
		recv_stall_pct = 24;
		hold_request = 1'b1;
		run_frames(250);
		settle_outputs();

		// Back to the widest screen; the sender pauses midway for the outputs.
		write_limits(16'd65535, 16'd4096);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_frames(150);
		settle_outputs();
		recv_stall_pct = 24;
		run_frames(150);
		settle_outputs();

		board.check_leftovers();
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog over the whole run.
	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
